FILE: hdl/char_stream_tokenizer_unit_defines.svh
// Assertion macros for the tokenizer RTL files; cst_outq is the only one that uses them.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CHAR_STREAM_TOKENIZER_UNIT_DEFINES_SVH
`define CHAR_STREAM_TOKENIZER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define CST_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define CST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define CST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/cst_pkg.sv
// Types and character constants for the character stream tokenizer.
// Depends on nothing; imported by every tokenizer module.
`default_nettype none

package cst_pkg;

    // Characters the scanner reacts to.
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SQUOT = 8'h27;

    // Width of an integer token value, enough for the signed 32-bit maximum.
    localparam int unsigned NUM_W = 31;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_INT  = 2'd2,
        MODE_ID   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        KIND_PLUS  = 4'd0,
        KIND_MINUS = 4'd1,
        KIND_EQ    = 4'd2,
        KIND_INT   = 4'd3,
        KIND_SCHR  = 4'd4,
        KIND_SEND  = 4'd5,
        KIND_ICHR  = 4'd6,
        KIND_IEND  = 4'd7,
        KIND_DROP  = 4'd8
    } t_kind;

    // Scanner state carried from one byte to the next.
    typedef struct packed {
        t_mode              mode;
        logic               halted;
        logic [NUM_W-1:0]   acc;
        logic               ovf;
    } t_scan_state;

    // One result token.
    typedef struct packed {
        t_kind              kind;
        logic [7:0]         symbol;
        logic [NUM_W-1:0]   number;
        logic               too_big;
    } t_res;

    // All results of one input byte: one, or two when two is set.
    typedef struct packed {
        logic               two;
        t_res               r0;
        t_res               r1;
    } t_item;

endpackage

`default_nettype wire

FILE: hdl/cst_step.sv
// Combinational scan step: next scanner state and results for one byte.
// Depends on cst_pkg.
`default_nettype none

module cst_step (
    input  wire cst_pkg::t_scan_state i_state,
    input  wire                       i_nul_ends,
    input  wire                       i_op,
    input  wire [7:0]                 i_text_byte,
    output cst_pkg::t_scan_state      o_state,
    output cst_pkg::t_item            o_item,
    output logic                      o_push
);
    import cst_pkg::*;

    // Decimal accumulate with saturation at the signed 32-bit maximum.
    function automatic logic [NUM_W:0] acc_digit(input logic [NUM_W-1:0] acc,
                                                  input logic [3:0] dig);
        logic [NUM_W+3:0] prod;
        begin
            prod = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{NUM_W{1'b0}}, dig};
            if (prod[NUM_W+3:NUM_W] != 4'd0) begin
                acc_digit = {1'b1, {NUM_W{1'b1}}};
            end else begin
                acc_digit = {1'b0, prod[NUM_W-1:0]};
            end
        end
    endfunction

    function automatic t_res mk_res(input t_kind kind, input logic [7:0] sym);
        t_res r;
        begin
            r.kind    = kind;
            r.symbol  = sym;
            r.number  = '0;
            r.too_big = 1'b0;
            mk_res    = r;
        end
    endfunction

    logic [7:0]     c;
    logic           is_digit;
    logic           is_alnum;
    logic           is_quote;
    logic           idle_go;
    logic           first_v;
    t_res           first_r;
    logic           idle_v;
    t_res           idle_r;
    logic [NUM_W:0] acc_cont;
    logic [NUM_W:0] acc_start;
    t_scan_state    st;

    // Character classes, plain ASCII.
    assign c        = i_op ? CH_NUL : i_text_byte;
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign is_alnum = is_digit || ((c >= 8'h41) && (c <= 8'h5A))
                               || ((c >= 8'h61) && (c <= 8'h7A));
    assign is_quote = (c == CH_DQUOT) || (c == CH_SQUOT);
    assign acc_cont  = acc_digit(i_state.acc, c[3:0]);
    assign acc_start = acc_digit('0, c[3:0]);

    // Mode handling, then the idle decision for a byte that is processed again.
    always_comb begin
        st      = i_state;
        idle_go = 1'b0;
        first_v = 1'b0;
        first_r = mk_res(KIND_PLUS, 8'h00);
        idle_v  = 1'b0;
        idle_r  = mk_res(KIND_PLUS, 8'h00);
        if (!i_state.halted) begin
            unique case (i_state.mode)
                MODE_STR: begin
                    first_v = 1'b1;
                    if (is_quote || (i_nul_ends && (c == CH_NUL))) begin
                        first_r = mk_res(KIND_SEND, 8'h00);
                        st.mode = MODE_IDLE;
                    end else if (i_op) begin
                        first_r = mk_res(KIND_DROP, 8'h00);
                        st.mode = MODE_IDLE;
                    end else begin
                        first_r = mk_res(KIND_SCHR, c);
                    end
                end
                MODE_INT: begin
                    if (is_digit) begin
                        st.acc = acc_cont[NUM_W-1:0];
                        st.ovf = i_state.ovf | acc_cont[NUM_W];
                    end else begin
                        first_v         = 1'b1;
                        first_r         = mk_res(KIND_INT, 8'h00);
                        first_r.number  = i_state.acc;
                        first_r.too_big = i_state.ovf;
                        st.acc          = '0;
                        st.ovf          = 1'b0;
                        st.mode         = MODE_IDLE;
                        idle_go         = 1'b1;
                    end
                end
                MODE_ID: begin
                    first_v = 1'b1;
                    if (is_alnum) begin
                        first_r = mk_res(KIND_ICHR, c);
                    end else begin
                        first_r = mk_res(KIND_IEND, 8'h00);
                        st.mode = MODE_IDLE;
                        idle_go = 1'b1;
                    end
                end
                default: begin
                    idle_go = 1'b1;
                end
            endcase
        end

        // Idle mode byte decode.
        if (idle_go) begin
            if (c == CH_NUL) begin
                st.halted = 1'b1;
            end else if (c == CH_PLUS) begin
                idle_v = 1'b1;
                idle_r = mk_res(KIND_PLUS, 8'h00);
            end else if (c == CH_MINUS) begin
                idle_v = 1'b1;
                idle_r = mk_res(KIND_MINUS, 8'h00);
            end else if (c == CH_EQ) begin
                idle_v = 1'b1;
                idle_r = mk_res(KIND_EQ, 8'h00);
            end else if (is_quote) begin
                st.mode = MODE_STR;
            end else if (is_digit) begin
                st.mode = MODE_INT;
                st.acc  = acc_start[NUM_W-1:0];
                st.ovf  = acc_start[NUM_W];
            end else if (c != CH_SPACE) begin
                st.mode = MODE_ID;
                idle_v  = 1'b1;
                idle_r  = mk_res(KIND_ICHR, c);
            end
        end

        // End of text returns the scanner to its reset state.
        if (i_op) begin
            st.mode   = MODE_IDLE;
            st.halted = 1'b0;
            st.acc    = '0;
            st.ovf    = 1'b0;
        end
    end

    // Pack the results in order of appearance.
    assign o_state   = st;
    assign o_push    = first_v | idle_v;
    assign o_item.two = first_v & idle_v;
    assign o_item.r0 = first_v ? first_r : idle_r;
    assign o_item.r1 = idle_r;

endmodule

`default_nettype wire

FILE: hdl/cst_outq.sv
// Two-entry result queue that hands out one or two results per entry.
// Depends on cst_pkg and the assertion macro header.
`default_nettype none

module cst_outq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire cst_pkg::t_item i_item,
    output logic                o_full,
    output logic                o_valid,
    input  wire                 i_ready,
    output cst_pkg::t_res       o_res,
    output logic                o_final
);
    import cst_pkg::*;
`include "char_stream_tokenizer_unit_defines.svh"

    t_item       r_q [2];
    logic        r_wr;
    logic        n_wr;
    logic        r_rd;
    logic        n_rd;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        r_sub;
    logic        n_sub;
    t_item       head;
    logic        fire;
    logic        pop;

    // Head entry and the result currently offered.
    assign head    = r_q[r_rd];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_final = r_sub | ~head.two;
    assign o_res   = r_sub ? head.r1 : head.r0;
    assign fire    = o_valid & i_ready;
    assign pop     = fire & o_final;

    // Pointer, fill count and sub-result index.
    always_comb begin
        n_wr    = r_wr ^ i_push;
        n_rd    = r_rd ^ pop;
        n_count = r_count + {1'b0, i_push} - {1'b0, pop};
        n_sub   = r_sub;
        if (fire) begin
            n_sub = ~o_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
            r_sub   <= 1'b0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
            r_sub   <= n_sub;
        end
    end

    // Entry storage, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_item;
        end
    end

    `CST_ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, r_count != 2'd3, "queue count out of range")
    `CST_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_push, !o_full && !(r_count == 2'd2), "push into full queue")
    `CST_ASSERT_IMPL(a_sub_two, i_clk, i_rst_n, r_sub, (r_count != 2'd0) && head.two, "second result offered for single-result entry")
    `CST_ASSERT_NEXT(a_second_follows, i_clk, i_rst_n, fire && !o_final, r_sub && (r_rd == $past(r_rd)), "second result did not follow first")

endmodule

`default_nettype wire

FILE: hdl/char_stream_tokenizer_unit.sv
// Top level of the character stream tokenizer: scanner state, config register, result queue.
// Depends on cst_pkg, cst_step and cst_outq.
`default_nettype none

// Byte-serial tokenizer. A byte or end-of-text item is accepted on every cycle in which the
// result queue has a free entry; the scan step is evaluated at the transfer and its results
// are registered in the two-item result queue that drives the output. Each item leaves zero,
// one or two results, and the result port delivers one per cycle while the receiver is ready,
// so items that each yield at most one result run at one item per cycle, while an item that
// ends an integer or identifier and also gives its own token puts out two results in turn.
// The nul_ends_tokens register may be written at any time the block is idle.
module char_stream_tokenizer_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire                          i_cfg_wr_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_op,
    input  wire  [7:0]                   i_text_byte,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [3:0]                   o_kind,
    output logic [7:0]                   o_symbol,
    output logic [cst_pkg::NUM_W-1:0]    o_number,
    output logic                         o_too_big,
    output logic                         o_final_res
);
    import cst_pkg::*;

    t_scan_state r_state;
    t_scan_state n_state;
    logic        r_nul_ends;
    t_item       step_item;
    logic        step_push;
    logic        in_xfer;
    logic        q_full;
    t_res        out_res;

    assign o_in_ready = ~q_full;
    assign in_xfer    = i_in_valid & o_in_ready;

    // Scan step for the byte on the input.
    cst_step u_step (
        .i_state     (r_state),
        .i_nul_ends  (r_nul_ends),
        .i_op        (i_op),
        .i_text_byte (i_text_byte),
        .o_state     (n_state),
        .o_item      (step_item),
        .o_push      (step_push)
    );

    // Scanner state advances on each input transfer; config on each write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode   <= MODE_IDLE;
            r_state.halted <= 1'b0;
            r_state.acc    <= '0;
            r_state.ovf    <= 1'b0;
            r_nul_ends     <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (i_cfg_wr_en) begin
                r_nul_ends <= i_cfg_wr_data;
            end
        end
    end

    // Results wait here until the output transfer.
    cst_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer & step_push),
        .i_item  (step_item),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res),
        .o_final (o_final_res)
    );

    assign o_kind    = out_res.kind;
    assign o_symbol  = out_res.symbol;
    assign o_number  = out_res.number;
    assign o_too_big = out_res.too_big;

endmodule

`default_nettype wire
